// ===== rtl/core/nta_pkg.sv =====
// Package for the nearest-track association block: field widths, codes,
// sequencer states and the track table entry type. No dependencies.
`default_nettype none

package nta_pkg;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int GATE_W     = 12;
    localparam int STALE_W    = 16;
    localparam int FRAME_W    = 32;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int TRACK_ID_W = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Defaults
    localparam int MAX_TRACKS_DEF = 64;
    localparam logic [GATE_W-1:0]  GATE_RESET  = GATE_W'(100);
    localparam logic [STALE_W-1:0] STALE_RESET = STALE_W'(300);

    // Operation codes
    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_FRAME  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_DECIDE
    } t_state;

    // One track table entry
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FRAME_W-1:0] frame;
    } t_track_entry;

endpackage

`default_nettype wire

// ===== rtl/core/nearest_track_association.sv =====
// Nearest-track association top level: sequencer, config registers, result
// register. Depends on nta_pkg, nta_sq_unit and nta_track_mem.
`default_nettype none

// A detection word (operation 0) is compared with every one of the N filled
// entries of the track table by integer squared distance. Only live entries
// count. The nearest one within the gate wins, with the lowest index on ties.
// Otherwise a new track is appended, or table full is reported. One squarer
// serves every square: first the gate square, then dx^2 and dy^2 of each
// entry, with a compare step after each entry. The table memory has a single
// read port and is walked three steps per entry. A new detection is accepted
// only once the previous one has been decided. If the previous result word
// has not been taken, the final decide step waits for it. A frame word
// (operation 1) returns nothing. Each detection returns one result word,
// held in an output register until taken. Configuration writes take effect
// at once and are meant for idle periods.
module nearest_track_association
    import nta_pkg::*;
#(
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_operation,
    input  wire logic [COORD_W-1:0]    i_box_x,
    input  wire logic [COORD_W-1:0]    i_box_y,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [TRACK_ID_W-1:0]      o_track_id,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRACKS);

    t_state r_state, n_state;

    logic [GATE_W-1:0]     r_gate;
    logic [STALE_W-1:0]    r_stale;
    logic [FRAME_W-1:0]    r_frame_count, n_frame_count;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [COORD_W-1:0]    r_bx, n_bx;
    logic [COORD_W-1:0]    r_by, n_by;
    logic [SQ_W-1:0]       r_gate_sq, n_gate_sq;
    logic [SQ_W-1:0]       r_sq_x, n_sq_x;
    logic [SQ_W-1:0]       r_sq_y, n_sq_y;
    logic                  r_live, n_live;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_best, n_best;
    logic [DIST_W-1:0]     r_best_d, n_best_d;
    logic                  r_out_valid, n_out_valid;
    logic [TRACK_ID_W-1:0] r_out_id, n_out_id;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;

    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    t_track_entry       mem_rd_data;
    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    t_track_entry       mem_wr_data;

    logic [COORD_W-1:0] sq_a;
    logic [COORD_W-1:0] sq_b;
    logic [SQ_W-1:0]    sq_res;

    logic [DIST_W-1:0]  sum_sq;
    logic [FRAME_W-1:0] age;
    logic [CNT_W-1:0]   idx_next;
    logic               match;
    logic [IDX_W-1:0]   sel_idx;
    logic [IDX_W+TRACK_ID_W-1:0] id_ext;

    nta_sq_unit u_sq (
        .i_a  (sq_a),
        .i_b  (sq_b),
        .o_sq (sq_res)
    );

    nta_track_mem #(
        .DEPTH  (MAX_TRACKS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate  <= GATE_RESET;
            r_stale <= STALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GATE:  r_gate  <= i_cfg_wdata[GATE_W-1:0];
                CFG_STALE: r_stale <= i_cfg_wdata[STALE_W-1:0];
                default:   ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_frame_count <= n_frame_count;
            r_count       <= n_count;
            r_out_valid   <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_bx         <= n_bx;
        r_by         <= n_by;
        r_gate_sq    <= n_gate_sq;
        r_sq_x       <= n_sq_x;
        r_sq_y       <= n_sq_y;
        r_live       <= n_live;
        r_found      <= n_found;
        r_best       <= n_best;
        r_best_d     <= n_best_d;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    // helper values
    always_comb begin
        sum_sq   = DIST_W'(r_sq_x) + DIST_W'(r_sq_y);
        age      = r_frame_count - mem_rd_data.frame;
        idx_next = r_idx + CNT_W'(1);
        match    = r_found && (r_best_d <= DIST_W'(r_gate_sq));
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state       = r_state;
        n_frame_count = r_frame_count;
        n_count       = r_count;
        n_idx         = r_idx;
        n_bx          = r_bx;
        n_by          = r_by;
        n_gate_sq     = r_gate_sq;
        n_sq_x        = r_sq_x;
        n_sq_y        = r_sq_y;
        n_live        = r_live;
        n_found       = r_found;
        n_best        = r_best;
        n_best_d      = r_best_d;
        n_out_valid   = r_out_valid;
        n_out_id      = r_out_id;
        n_out_status  = r_out_status;
        o_in_ready    = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = r_idx[IDX_W-1:0];
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_best;
        mem_wr_data   = '{x: r_bx, y: r_by, frame: r_frame_count};
        sq_a          = r_gate;
        sq_b          = '0;
        sel_idx       = r_best;

        // result word leaves
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_operation == OP_FRAME) begin
                        n_frame_count = r_frame_count + FRAME_W'(1);
                    end else begin
                        n_bx    = i_box_x;
                        n_by    = i_box_y;
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_state = ST_GATE;
                    end
                end
            end
            // gate squared, and first table read
            ST_GATE: begin
                sq_a      = r_gate;
                sq_b      = '0;
                n_gate_sq = sq_res;
                if (r_count == '0) begin
                    n_state = ST_DECIDE;
                end else begin
                    mem_rd_en = 1'b1;
                    n_state   = ST_SQX;
                end
            end
            ST_SQX: begin
                sq_a    = mem_rd_data.x;
                sq_b    = r_bx;
                n_sq_x  = sq_res;
                n_live  = (age < FRAME_W'(r_stale));
                n_state = ST_SQY;
            end
            ST_SQY: begin
                sq_a    = mem_rd_data.y;
                sq_b    = r_by;
                n_sq_y  = sq_res;
                n_state = ST_CMP;
            end
            // keep the nearest live entry, read the next one
            ST_CMP: begin
                if (r_live && (!r_found || (sum_sq < r_best_d))) begin
                    n_found  = 1'b1;
                    n_best   = r_idx[IDX_W-1:0];
                    n_best_d = sum_sq;
                end
                if (idx_next < r_count) begin
                    n_idx       = idx_next;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_next[IDX_W-1:0];
                    n_state     = ST_SQX;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            // match, append or report full once the result register is free
            ST_DECIDE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (match) begin
                        sel_idx      = r_best;
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = r_best;
                        n_out_status = STATUS_MATCH;
                    end else if (r_count != CNT_MAX) begin
                        sel_idx      = r_count[IDX_W-1:0];
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = r_count[IDX_W-1:0];
                        n_count      = r_count + CNT_W'(1);
                        n_out_status = STATUS_NEW;
                    end else begin
                        sel_idx      = '0;
                        n_out_status = STATUS_FULL;
                    end
                    id_ext   = {{TRACK_ID_W{1'b0}}, sel_idx};
                    n_out_id = id_ext[TRACK_ID_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        id_ext = {{TRACK_ID_W{1'b0}}, sel_idx};
    end

    assign o_out_valid = r_out_valid;
    assign o_track_id  = r_out_id;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    // table never holds more tracks than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("track count beyond table depth");

    // the scan only visits filled entries
    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQX || r_state == ST_SQY || r_state == ST_CMP)
            |-> (r_idx < r_count))
        else $error("scan index past filled entries");

    // table full is reported only with a full table
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_FULL) |-> (r_count == CNT_MAX))
        else $error("table full reported with free entries");

    // a new track always grows the table by one
    a_new_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && n_out_valid && !r_out_valid && n_out_status == STATUS_NEW)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("new track without table growth");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nta_sq_unit.sv =====
// Shared squared-difference unit: (a - b)^2 for two unsigned coordinates.
// Depends on nta_pkg.
`default_nettype none

module nta_sq_unit
    import nta_pkg::*;
(
    input  wire logic [COORD_W-1:0] i_a,
    input  wire logic [COORD_W-1:0] i_b,
    output logic      [SQ_W-1:0]    o_sq
);

    logic [COORD_W-1:0] diff;

    // absolute difference, then one square
    always_comb begin
        diff = (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);
        o_sq = SQ_W'(diff) * SQ_W'(diff);
    end

endmodule

`default_nettype wire

// ===== rtl/core/nta_track_mem.sv =====
// Track table memory: one write port, one read port with registered data.
// Depends on nta_pkg.
`default_nettype none

module nta_track_mem
    import nta_pkg::*;
#(
    parameter int DEPTH  = MAX_TRACKS_DEF,
    parameter int ADDR_W = 6
) (
    input  wire logic         i_clk,
    input  wire logic         i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_track_entry i_wr_data,
    input  wire logic         i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output t_track_entry      o_rd_data
);

    t_track_entry r_mem [DEPTH];
    t_track_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
